// ===== rtl/pf_pkg.sv =====
// Shared types, constants and key square helpers for the Playfair stream encryptor.
// No dependencies; used by every module under rtl/.
package pf_pkg;

  localparam int unsigned NumRows  = 5;
  localparam int unsigned NumCols  = 5;
  localparam int unsigned LetterW  = 5;
  localparam int unsigned KeyRowW  = NumCols * LetterW;
  localparam int unsigned RowIdxW  = $clog2(NumRows);
  localparam int unsigned ColIdxW  = $clog2(NumCols);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [ByteW-1:0]   ChSpace  = 8'd32;
  localparam logic [ByteW-1:0]   ChLowA   = 8'd97;
  localparam logic [ByteW-1:0]   ChLowI   = 8'd105;
  localparam logic [ByteW-1:0]   ChLowJ   = 8'd106;
  localparam logic [ByteW-1:0]   ChLowZ   = 8'd122;
  localparam logic [CharW-1:0]   ChUpA    = 7'd65;
  localparam logic [LetterW-1:0] FillerCode = 5'd23;  // 'x'
  localparam logic [LetterW-1:0] CodeI      = 5'd8;   // 'i'

  typedef logic [NumCols-1:0][LetterW-1:0] key_row_t;
  typedef logic [NumRows-1:0][NumCols-1:0][LetterW-1:0] key_sq_t;

  localparam key_sq_t KeyReset = {25'd16374553, 25'd10963639, 25'd5518900,
                                   25'd2235792, 25'd36043};

  // One queued operation: a digraph to encrypt, or a bad-byte marker.
  typedef struct packed {
    logic               is_bad;
    logic               last;
    logic [LetterW-1:0] a;
    logic [LetterW-1:0] b;
  } op_t;

  typedef struct packed {
    logic [RowIdxW-1:0] row;
    logic [ColIdxW-1:0] col;
  } loc_t;

  // First match in row-major order; no match lands at row 0, column 0.
  function automatic loc_t key_locate(key_sq_t key, logic [LetterW-1:0] code);
    loc_t loc;
    loc = '0;
    for (int r = NumRows - 1; r >= 0; r--) begin
      for (int c = NumCols - 1; c >= 0; c--) begin
        if (key[r][c] == code) begin
          loc.row = RowIdxW'(r);
          loc.col = ColIdxW'(c);
        end
      end
    end
    return loc;
  endfunction

  function automatic logic [RowIdxW-1:0] row_next(logic [RowIdxW-1:0] r);
    return (r == RowIdxW'(NumRows - 1)) ? '0 : RowIdxW'(r + 1'b1);
  endfunction

  function automatic logic [ColIdxW-1:0] col_next(logic [ColIdxW-1:0] c);
    return (c == ColIdxW'(NumCols - 1)) ? '0 : ColIdxW'(c + 1'b1);
  endfunction

endpackage

// ===== rtl/pf_front.sv =====
// Front end: accepts plaintext bytes, tracks digraph and repeat state,
// and queues digraph / bad-byte operations. Depends on pf_pkg.
module pf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pf_pkg::ByteW-1:0]  in_byte_i,
  input  logic                      in_last_i,
  output logic                      push_valid_o,
  output pf_pkg::op_t               push_op_o,
  input  logic                      push_ready_i
);

  logic                         held_q, held_d;
  logic [pf_pkg::LetterW-1:0]   held_letter_q, held_letter_d;
  logic [pf_pkg::ByteW-1:0]     prev_q, prev_d;
  logic                         seen_q, seen_d;
  logic                         pend_q, pend_d;
  pf_pkg::op_t                  pend_op_q, pend_op_d;

  logic                         accept;
  logic                         is_space, is_letter, repeat_hit;
  logic [pf_pkg::LetterW-1:0]   code;
  logic                         body_v, flush_v;
  pf_pkg::op_t                  body_op, flush_op;
  logic                         h1;
  logic [pf_pkg::LetterW-1:0]   hl1;

  assign in_ready_o = !pend_q && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_space  = (in_byte_i == pf_pkg::ChSpace);
    is_letter = (in_byte_i >= pf_pkg::ChLowA) && (in_byte_i <= pf_pkg::ChLowZ);
    code      = (in_byte_i == pf_pkg::ChLowJ) ? pf_pkg::CodeI
                                              : pf_pkg::LetterW'(in_byte_i - pf_pkg::ChLowA);
    // i/j count as a repeat of each other
    repeat_hit = seen_q && ((in_byte_i == prev_q) ||
                 ((in_byte_i == pf_pkg::ChLowI) && (prev_q == pf_pkg::ChLowJ)) ||
                 ((in_byte_i == pf_pkg::ChLowJ) && (prev_q == pf_pkg::ChLowI)));

    body_v  = 1'b0;
    body_op = '0;
    h1      = held_q;
    hl1     = held_letter_q;

    if (is_letter) begin
      if (repeat_hit) begin
        if (held_q) begin
          body_v    = 1'b1;
          body_op.a = held_letter_q;
          body_op.b = pf_pkg::FillerCode;
          h1        = 1'b1;
          hl1       = code;
        end else begin
          body_v    = 1'b1;
          body_op.a = pf_pkg::FillerCode;
          body_op.b = code;
          h1        = 1'b0;
        end
      end else if (held_q) begin
        body_v    = 1'b1;
        body_op.a = held_letter_q;
        body_op.b = code;
        h1        = 1'b0;
      end else begin
        h1  = 1'b1;
        hl1 = code;
      end
    end else if (!is_space) begin
      body_v         = 1'b1;
      body_op.is_bad = 1'b1;
    end

    flush_v         = in_last_i && h1;
    flush_op        = '0;
    flush_op.a      = hl1;
    flush_op.b      = pf_pkg::FillerCode;
    flush_op.last   = 1'b1;
    body_op.last    = in_last_i && !flush_v;

    push_valid_o = pend_q || (accept && (body_v || flush_v));
    push_op_o    = pend_q ? pend_op_q : (body_v ? body_op : flush_op);
  end

  always_comb begin
    held_d        = held_q;
    held_letter_d = held_letter_q;
    prev_d        = prev_q;
    seen_d        = seen_q;
    pend_d        = pend_q;
    pend_op_d     = pend_op_q;

    if (pend_q && push_ready_i) begin
      pend_d = 1'b0;
    end

    if (accept) begin
      if (in_last_i) begin
        held_d        = 1'b0;
        held_letter_d = '0;
        prev_d        = '0;
        seen_d        = 1'b0;
      end else begin
        held_d        = h1;
        held_letter_d = hl1;
        if (is_letter || is_space) begin
          prev_d = in_byte_i;
          seen_d = 1'b1;
        end
      end
      // two transactions from one item: flush waits in the pending register until the queue takes it
      if (body_v && flush_v) begin
        pend_d    = 1'b1;
        pend_op_d = flush_op;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= 1'b0;
      held_letter_q <= '0;
      prev_q        <= '0;
      seen_q        <= 1'b0;
      pend_q        <= 1'b0;
    end else begin
      held_q        <= held_d;
      held_letter_q <= held_letter_d;
      prev_q        <= prev_d;
      seen_q        <= seen_d;
      pend_q        <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_op_q <= pend_op_d;
  end

endmodule

// ===== rtl/pf_fifo.sv =====
// Small operation queue between front and back end.
// Depends on pf_pkg for the op_t payload.
module pf_fifo #(
  parameter int unsigned Depth = pf_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  pf_pkg::op_t push_op_i,
  output logic        push_ready_o,
  output logic        pop_valid_o,
  output pf_pkg::op_t pop_op_o,
  input  logic        pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pf_pkg::op_t       mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== rtl/pf_back.sv =====
// Back end: locates digraph letters in the key square, applies the Playfair
// rules and serializes cipher letters onto the output. Depends on pf_pkg.
module pf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pf_pkg::key_sq_t           key_i,
  input  logic                      pop_valid_i,
  input  pf_pkg::op_t               pop_op_i,
  output logic                      pop_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pf_pkg::CharW-1:0]  out_char_o,
  output logic                      out_bad_o,
  output logic                      out_last_o
);

  // stage 1: located digraph
  logic          s1_valid_q, s1_valid_d;
  logic          s1_bad_q, s1_last_q;
  pf_pkg::loc_t  s1_loc_a_q, s1_loc_b_q;

  // stage 2: output register plus second letter of the pair
  logic                       s2_valid_q, s2_valid_d;
  logic                       s2_sec_q, s2_sec_d;
  logic [pf_pkg::CharW-1:0]   s2_char_q, s2_char_d, s2_sec_char_q, s2_sec_char_d;
  logic                       s2_bad_q, s2_bad_d;
  logic                       s2_last_q, s2_last_d, s2_sec_last_q, s2_sec_last_d;

  logic                       s2_free, s1_adv, s1_load;
  logic [pf_pkg::LetterW-1:0] x, y;
  logic [pf_pkg::RowIdxW-1:0] ra, rb;
  logic [pf_pkg::ColIdxW-1:0] ca, cb;

  assign s2_free     = !s2_valid_q || (out_ready_i && !s2_sec_q);
  assign s1_adv      = s1_valid_q && s2_free;
  assign pop_ready_o = !s1_valid_q || s1_adv;
  assign s1_load     = pop_valid_i && pop_ready_o;

  always_comb begin
    ra = s1_loc_a_q.row;
    ca = s1_loc_a_q.col;
    rb = s1_loc_b_q.row;
    cb = s1_loc_b_q.col;
    if (ra == rb) begin
      x = key_i[ra][pf_pkg::col_next(ca)];
      y = key_i[rb][pf_pkg::col_next(cb)];
    end else if (ca == cb) begin
      x = key_i[pf_pkg::row_next(ra)][ca];
      y = key_i[pf_pkg::row_next(rb)][cb];
    end else begin
      x = key_i[ra][cb];
      y = key_i[rb][ca];
    end
  end

  always_comb begin
    s1_valid_d    = s1_valid_q;
    s2_valid_d    = s2_valid_q;
    s2_sec_d      = s2_sec_q;
    s2_char_d     = s2_char_q;
    s2_bad_d      = s2_bad_q;
    s2_last_d     = s2_last_q;
    s2_sec_char_d = s2_sec_char_q;
    s2_sec_last_d = s2_sec_last_q;

    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    if (s1_adv) begin
      s2_valid_d = 1'b1;
      if (s1_bad_q) begin
        s2_char_d = '0;
        s2_bad_d  = 1'b1;
        s2_last_d = s1_last_q;
        s2_sec_d  = 1'b0;
      end else begin
        s2_char_d     = pf_pkg::ChUpA + pf_pkg::CharW'(x);
        s2_bad_d      = 1'b0;
        s2_last_d     = 1'b0;
        s2_sec_d      = 1'b1;
        s2_sec_char_d = pf_pkg::ChUpA + pf_pkg::CharW'(y);
        s2_sec_last_d = s1_last_q;
      end
    end else if (s2_valid_q && out_ready_i) begin
      if (s2_sec_q) begin
        s2_char_d = s2_sec_char_q;
        s2_last_d = s2_sec_last_q;
        s2_bad_d  = 1'b0;
        s2_sec_d  = 1'b0;
      end else begin
        s2_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_sec_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s2_sec_q   <= s2_sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_bad_q   <= pop_op_i.is_bad;
      s1_last_q  <= pop_op_i.last;
      s1_loc_a_q <= pf_pkg::key_locate(key_i, pop_op_i.a);
      s1_loc_b_q <= pf_pkg::key_locate(key_i, pop_op_i.b);
    end
    s2_char_q     <= s2_char_d;
    s2_bad_q      <= s2_bad_d;
    s2_last_q     <= s2_last_d;
    s2_sec_char_q <= s2_sec_char_d;
    s2_sec_last_q <= s2_sec_last_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_char_o  = s2_char_q;
  assign out_bad_o   = s2_bad_q;
  assign out_last_o  = s2_last_q;

endmodule

// ===== rtl/playfair_stream_encryptor.sv =====
// Top level of the Playfair stream encryptor: key square registers,
// front end, operation queue and back end. Depends on pf_pkg, pf_front, pf_fifo, pf_back.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata = plain_byte, tlast = is_last
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata = cipher_char, tuser = bad_input,
//                                              tlast = text_end
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i = key row, cfg_data_i = row
//
// One input byte per cycle while the queue has room; an end-of-text byte that needs
// a filler digraph in addition to its own transaction holds tready low until the filler is queued.
// Each digraph holds the output register for its two cipher letters in turn, so
// sustained output is one letter per cycle while m_axis_tready is high. The queue
// entry is written at the accepting edge; the key lookup register and then the output
// register lie between it and the first letter on m_axis. Reset clears all
// control state and loads the default key square; cfg writes are always accepted.
module playfair_stream_encryptor #(
  parameter int unsigned FifoDepth = pf_pkg::FifoDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pf_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] plain_byte
  input  logic                         s_axis_tlast,   // is_last
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pf_pkg::OutDataW-1:0]  m_axis_tdata,   // [6:0] cipher_char, [7] zero
  output logic                         m_axis_tuser,   // [0] bad_input
  output logic                         m_axis_tlast,   // text_end
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pf_pkg::KeyRowW-1:0]   cfg_data_i
);

  pf_pkg::key_sq_t           key_q;
  logic                      push_valid, push_ready, pop_valid, pop_ready;
  pf_pkg::op_t               push_op, pop_op;
  logic [pf_pkg::CharW-1:0]  out_char;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= pf_pkg::KeyReset;
    end else if (cfg_valid_i && (cfg_index_i < pf_pkg::CfgIdxW'(pf_pkg::NumRows))) begin
      key_q[cfg_index_i] <= cfg_data_i;
    end
  end

  pf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_op_o    (push_op),
    .push_ready_i (push_ready)
  );

  pf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_op_i    (push_op),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_op_o     (pop_op),
    .pop_ready_i  (pop_ready)
  );

  pf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .pop_valid_i (pop_valid),
    .pop_op_i    (pop_op),
    .pop_ready_o (pop_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .out_bad_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

// ===== tb/sv/tb_playfair_stream_encryptor.sv =====
// Self-checking testbench for playfair_stream_encryptor: stream driver, result monitor,
// an in-bench Playfair predictor and key square writes over the cfg channel.
// Depends on pf_pkg and rtl/playfair_stream_encryptor.sv.
module tb_playfair_stream_encryptor;

  typedef enum logic [pf_pkg::CfgIdxW-1:0] {
    RegKeyRow0, RegKeyRow1, RegKeyRow2, RegKeyRow3, RegKeyRow4,
    RegUnused5, RegUnused6, RegUnused7
  } cfg_reg_e;

  typedef struct packed {
    logic [pf_pkg::ByteW-1:0] data;
    logic                     last;
  } plain_item_t;

  typedef struct packed {
    logic [pf_pkg::CharW-1:0] ch;
    logic                     bad;
    logic                     done;
  } cipher_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [pf_pkg::ByteW-1:0]    s_axis_tdata  = '0;
  logic                        s_axis_tlast  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [pf_pkg::OutDataW-1:0] m_axis_tdata;
  logic                        m_axis_tuser;
  logic                        m_axis_tlast;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [pf_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [pf_pkg::KeyRowW-1:0]  cfg_data_i    = '0;

  playfair_stream_encryptor dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // plaintext waiting to be driven, cipher letters still owed by the block
  plain_item_t item_q[$];
  cipher_t     cipher_q[$];
  int          queued_n   = 0;
  int          accepted_n = 0;
  int          fail_cnt   = 0;

  // predictor state
  pf_pkg::key_sq_t            key_sq;
  logic [pf_pkg::LetterW-1:0] held_code;
  logic                       held_ok;
  logic [pf_pkg::ByteW-1:0]   last_raw;
  logic                       text_open;
  int                         step_n;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void push_result(input logic [pf_pkg::CharW-1:0] ch, input logic bad);
    cipher_q.push_back('{ch: ch, bad: bad, done: 1'b0});
    step_n++;
  endfunction

  function automatic void find_letter(input logic [pf_pkg::LetterW-1:0] code,
                                      output int row, output int col);
    bit found;
    found = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < pf_pkg::NumRows; r++) begin
      for (int c = 0; c < pf_pkg::NumCols; c++) begin
        if (!found && key_sq[r][c] == code) begin
          found = 1'b1;
          row = r;
          col = c;
        end
      end
    end
  endfunction

  function automatic void encipher_pair(input logic [pf_pkg::LetterW-1:0] a,
                                        input logic [pf_pkg::LetterW-1:0] b);
    int r1, c1, r2, c2;
    logic [pf_pkg::LetterW-1:0] x, y;
    find_letter(a, r1, c1);
    find_letter(b, r2, c2);
    if (r1 == r2) begin
      x = key_sq[r1][(c1 + 1) % pf_pkg::NumCols];
      y = key_sq[r2][(c2 + 1) % pf_pkg::NumCols];
    end else if (c1 == c2) begin
      x = key_sq[(r1 + 1) % pf_pkg::NumRows][c1];
      y = key_sq[(r2 + 1) % pf_pkg::NumRows][c2];
    end else begin
      x = key_sq[r1][c2];
      y = key_sq[r2][c1];
    end
    push_result(pf_pkg::ChUpA + pf_pkg::CharW'(x), 1'b0);
    push_result(pf_pkg::ChUpA + pf_pkg::CharW'(y), 1'b0);
  endfunction

  function automatic void take_letter(input logic [pf_pkg::LetterW-1:0] code);
    if (held_ok) begin
      encipher_pair(held_code, code);
      held_ok = 1'b0;
    end else begin
      held_code = code;
      held_ok = 1'b1;
    end
  endfunction

  function automatic void encrypt_byte(input logic [pf_pkg::ByteW-1:0] b, input logic last);
    logic [pf_pkg::LetterW-1:0] code;
    step_n = 0;
    if (b == pf_pkg::ChSpace) begin
      last_raw = b;
      text_open = 1'b1;
    end else if (b >= pf_pkg::ChLowA && b <= pf_pkg::ChLowZ) begin
      code = (b == pf_pkg::ChLowJ) ? pf_pkg::CodeI : pf_pkg::LetterW'(b - pf_pkg::ChLowA);
      // doubled letter, or i next to j, gets an x filler first
      if (text_open && (b == last_raw ||
                        (b == pf_pkg::ChLowI && last_raw == pf_pkg::ChLowJ) ||
                        (b == pf_pkg::ChLowJ && last_raw == pf_pkg::ChLowI)))
        take_letter(pf_pkg::FillerCode);
      take_letter(code);
      last_raw = b;
      text_open = 1'b1;
    end else begin
      push_result('0, 1'b1);
    end
    if (last) begin
      if (held_ok) take_letter(pf_pkg::FillerCode);
      held_ok = 1'b0;
      held_code = '0;
      text_open = 1'b0;
      last_raw = '0;
      if (step_n > 0) cipher_q[$].done = 1'b1;
    end
  endfunction

  // plaintext driver
  int tx_wait = 0;
  bit tx_burst = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    plain_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      tx_wait       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encrypt_byte(s_axis_tdata, s_axis_tlast);
        accepted_n++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait <= tx_wait - 1;
          s_axis_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          it = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= it.data;
          s_axis_tlast  <= it.last;
          tx_wait <= tx_burst ? 0 : $urandom_range(0, 11);
          if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // cipher monitor and receiver back-pressure
  int rx_wait = 0;
  bit rx_burst = 1'b0;
  bit long_hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_t exp;
    int gap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected transaction: cipher_char %0d bad_input %0b text_end %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_cnt++;
      end else begin
        exp = cipher_q.pop_front();
        if (m_axis_tdata !== {1'b0, exp.ch}) begin
          $error("cipher_char: expected %0d, actual %0d", exp.ch, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tuser !== exp.bad) begin
          $error("bad_input: expected %0b, actual %0b", exp.bad, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tlast !== exp.done) begin
          $error("text_end: expected %0b, actual %0b", exp.done, m_axis_tlast);
          fail_cnt++;
        end
      end
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      // one long hold while plenty of plaintext is still queued
      if (!long_hold_done && item_q.size() > 40) begin
        gap = 400;
        long_hold_done = 1'b1;
      end
      rx_wait <= gap;
      m_axis_tready <= (gap == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic queue_item(input logic [pf_pkg::ByteW-1:0] b, input logic last);
    item_q.push_back('{data: b, last: last});
    queued_n++;
  endtask

  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) queue_item(s[k], k == s.len() - 1);
  endtask

  task automatic queue_random_text(input int len);
    logic [pf_pkg::ByteW-1:0] b, prev;
    int sel;
    prev = pf_pkg::ChLowA + pf_pkg::ByteW'($urandom_range(0, 25));
    for (int k = 0; k < len; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) b = prev;
      else if (sel < 22) b = (prev == pf_pkg::ChLowI) ? pf_pkg::ChLowJ : pf_pkg::ChLowI;
      else if (sel < 34) b = pf_pkg::ChSpace;
      else if (sel < 38) b = pf_pkg::ByteW'($urandom_range(0, 255));
      else b = pf_pkg::ChLowA + pf_pkg::ByteW'($urandom_range(0, 25));
      queue_item(b, k == len - 1);
      prev = b;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_n != queued_n || cipher_q.size() != 0);
    // texts ending in a space yield nothing; let the pipeline settle
    repeat (12) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n_items, input bit with_pauses);
    int n, len;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(pf_pkg::ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n++;
      end
      len = $urandom_range(1, 12);
      queue_random_text(len);
      n += len;
      if (with_pauses && $urandom_range(0, 5) == 0) wait_idle();
    end
    wait_idle();
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [pf_pkg::KeyRowW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx <= RegKeyRow4) key_sq[idx] = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_key(input pf_pkg::key_sq_t k);
    for (int r = RegKeyRow0; r <= RegKeyRow4; r++) write_reg(cfg_reg_e'(r), k[r]);
    // indexes past the key square must be ignored
    for (int r = RegUnused5; r <= RegUnused7; r++)
      write_reg(cfg_reg_e'(r), pf_pkg::KeyRowW'($urandom_range(0, 32'h1FF_FFFF)));
  endtask

  function automatic pf_pkg::key_sq_t shuffled_key();
    logic [pf_pkg::LetterW-1:0] codes[pf_pkg::NumRows*pf_pkg::NumCols];
    logic [pf_pkg::LetterW-1:0] t;
    pf_pkg::key_sq_t k;
    int n, j;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != 9) begin
        codes[n] = pf_pkg::LetterW'(c);
        n++;
      end
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = codes[i];
      codes[i] = codes[j];
      codes[j] = t;
    end
    for (int i = 0; i < n; i++) k[i / pf_pkg::NumCols][i % pf_pkg::NumCols] = codes[i];
    return k;
  endfunction

  function automatic pf_pkg::key_sq_t raw_key();
    pf_pkg::key_sq_t k;
    for (int r = 0; r < pf_pkg::NumRows; r++)
      k[r] = pf_pkg::KeyRowW'($urandom_range(0, 32'h1FF_FFFF));
    return k;
  endfunction

  initial begin
    key_sq    = pf_pkg::KeyReset;
    held_code = '0;
    held_ok   = 1'b0;
    last_raw  = '0;
    text_open = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset key
    queue_text("hello");                      // doubled letter
    queue_text("ij ji");                      // i next to j, space breaks adjacency
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h41, 1'b0);
    queue_text("az");
    queue_item(pf_pkg::ChSpace, 1'b1);        // end of text with nothing to emit
    queue_item("q", 1'b0);
    queue_item(8'h7B, 1'b1);                  // bad byte closes text, flush follows
    queue_text("xx");
    queue_item(8'h60, 1'b1);
    queue_text("jj");
    wait_idle();

    load_key(shuffled_key());
    random_phase(80, 1'b0);
    load_key('0);                             // every cell holds a
    queue_text("abba");
    random_phase(20, 1'b1);
    load_key('1);                             // codes past z
    random_phase(20, 1'b1);
    load_key(raw_key());
    random_phase(40, 1'b1);
    load_key(shuffled_key());
    random_phase(60, 1'b1);

    if (fail_cnt == 0) $display("playfair_stream_encryptor regression: pass");
    else $display("playfair_stream_encryptor regression: fail");
    $finish;
  end

  initial begin
    #(12 * 200_000);
    $display("playfair_stream_encryptor regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pf_pkg.sv
rtl/pf_front.sv
rtl/pf_fifo.sv
rtl/pf_back.sv
rtl/playfair_stream_encryptor.sv
tb/sv/tb_playfair_stream_encryptor.sv
